// ----- rtl/inverse_variance_weighted_mean_assert.svh -----
// Assertion macros shared by the weighted-mean RTL.
// Depends on nothing; included by the top level.
`ifndef INVERSE_VARIANCE_WEIGHTED_MEAN_ASSERT_SVH
`define INVERSE_VARIANCE_WEIGHTED_MEAN_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IVWM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ivwm assertion failed");

// Next-cycle implication, disabled during reset.
`define IVWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ivwm assertion failed");

`endif

// ----- rtl/ivwm_pkg.sv -----
// Shared widths, constants and control types for the weighted-mean block.
// Depends on nothing; imported by every module of the block.
package ivwm_pkg;

    localparam int VALUE_W           = 32;
    localparam int ERROR_W           = 32;
    localparam int ACC_W             = 64;
    localparam int FRACTION_BITS_DEF = 16;

    // Serial multiplier: a 32-bit operand scanned bit by bit against a 64-bit one.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 64;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Square root produces one result bit per step.
    localparam int ROOT_W     = 32;
    localparam int ROOT_STEPS = ROOT_W;

    // Numerator 1.0 for the reciprocal divisions.
    localparam logic [ACC_W-1:0] DIV_ONE = 64'd1;

    // Clamp limits of the mean magnitude.
    localparam logic [ACC_W-1:0] MEAN_POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [ACC_W-1:0] MEAN_NEG_LIMIT = 64'h0000_0000_8000_0000;

    // Signed 64-bit saturation values.
    localparam logic [ACC_W-1:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] SUM_MIN = 64'h8000_0000_0000_0000;

    // Divider command and status.
    typedef struct packed {
        logic start;
        logic long_shift;
    } div_ctl_t;

    typedef struct packed {
        logic done;
        logic sat;
    } div_stat_t;

endpackage

// ----- rtl/inverse_variance_weighted_mean.sv -----
// Inverse-variance weighted mean over a stream of Q-format samples.
// Depends on ivwm_pkg, ivwm_mul, ivwm_div and the assertion macro header.
//
// Each sample word carries a signed value and an unsigned error; samples that are excluded,
// not finite or have zero error are skipped. A used sample goes through a serial multiply
// for the squared error, a radix-2 divide of 64 + 3*FRACTION_BITS steps for the weight, and
// a second serial multiply for value times weight, all on one shared multiplier and one
// shared divider. For the sample marked last the block then forms the mean (divide of
// 64 + FRACTION_BITS steps) and the error (divide of 64 + 3*FRACTION_BITS steps and a 32-step
// square root), after which the result word is registered and the sums cleared.
// The block takes new samples while a result word waits on the output.
module inverse_variance_weighted_mean
    import ivwm_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  logic signed [VALUE_W-1:0] sample_value,
    input  logic        [ERROR_W-1:0] sample_error,
    input  logic                      not_finite,
    input  logic                      excluded,
    input  logic                      last_sample,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic signed [VALUE_W-1:0] mean_value,
    output logic        [ERROR_W-1:0] mean_error,
    output logic                      no_samples,
    output logic                      overflowed
);

`include "inverse_variance_weighted_mean_assert.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL_EE = 4'd1;
    localparam logic [3:0] S_DIV_W  = 4'd2;
    localparam logic [3:0] S_MUL_VW = 4'd3;
    localparam logic [3:0] S_ACC    = 4'd4;
    localparam logic [3:0] S_RES    = 4'd5;
    localparam logic [3:0] S_DIV_M  = 4'd6;
    localparam logic [3:0] S_DIV_E  = 4'd7;
    localparam logic [3:0] S_SQRT   = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    localparam int SQ_CNT_W = $clog2(ROOT_STEPS + 1);
    localparam int REM_W    = ROOT_W + 1;

    logic [3:0]          state_reg, state_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic                last_reg, last_next;
    logic [ACC_W-1:0]    w_reg, w_next;
    logic                wsat_reg, wsat_next;
    logic [ACC_W-1:0]    term_reg, term_next;
    logic                tsat_reg, tsat_next;
    logic [ACC_W-1:0]    ws_reg, ws_next;
    logic [ACC_W-1:0]    wt_reg, wt_next;
    logic                used_reg, used_next;
    logic                sat_reg, sat_next;
    logic [VALUE_W-1:0]  mean_stage_reg, mean_stage_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ACC_W-1:0]    x_reg, x_next;
    logic [SQ_CNT_W-1:0] sq_cnt_reg, sq_cnt_next;
    logic                result_valid_reg, result_valid_next;
    logic [VALUE_W-1:0]  mean_value_reg, mean_value_next;
    logic [ERROR_W-1:0]  mean_error_reg, mean_error_next;
    logic                no_samples_reg, no_samples_next;
    logic                overflowed_reg, overflowed_next;

    logic                accept;
    logic                use_sample;
    logic                emit_load;
    logic [VALUE_W-1:0]  in_mag;

    logic                mul_start;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic                mul_done;
    logic [PROD_W-1:0]   mul_p;

    div_ctl_t            div_ctl;
    div_stat_t           div_stat;
    logic [ACC_W-1:0]    div_n;
    logic [ACC_W-1:0]    div_d;
    logic [ACC_W-1:0]    div_q;

    logic                t_ovf;
    logic [ACC_W-2:0]    t_mag;
    logic [ACC_W-1:0]    t_pos;
    logic [ACC_W:0]      ws_sum;
    logic                ws_ovf;
    logic [ACC_W:0]      wt_sum;
    logic [ACC_W-1:0]    ws_mag;
    logic [REM_W+1:0]    sq_rem_sh;
    logic [REM_W+1:0]    sq_trial;
    logic [REM_W+1:0]    sq_diff;
    logic                sq_ge;

    // Handshake and sample screening.
    assign sample_ready = (state_reg == S_IDLE);
    assign accept       = sample_valid & sample_ready;
    assign use_sample   = !not_finite && !excluded && (sample_error != '0);
    assign in_mag       = sample_value[VALUE_W-1] ? (~sample_value + VALUE_W'(1))
                                                  : sample_value;
    assign emit_load    = (state_reg == S_EMIT) && (!result_valid_reg || result_ready);

    // Multiplier operands: squared error first, then magnitude times weight.
    assign mul_start = (accept && use_sample) || ((state_reg == S_DIV_W) && div_stat.done);
    assign mul_a     = (state_reg == S_IDLE) ? sample_error : mag_reg;
    assign mul_b     = (state_reg == S_IDLE) ? {{(MUL_B_W-ERROR_W){1'b0}}, sample_error} : div_q;

    ivwm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // Divider commands: weight, mean and reciprocal of the weight total.
    assign ws_mag = ws_reg[ACC_W-1] ? (~ws_reg + ACC_W'(1)) : ws_reg;

    always_comb
    begin
        div_ctl.start      = 1'b0;
        div_ctl.long_shift = 1'b0;
        div_n              = DIV_ONE;
        div_d              = wt_reg;
        case (state_reg)
            S_MUL_EE:
            begin
                div_ctl.start      = mul_done;
                div_ctl.long_shift = 1'b1;
                div_d              = mul_p[ACC_W-1:0];
            end
            S_RES:
            begin
                div_ctl.start = used_reg && (wt_reg != '0);
                div_n         = ws_mag;
            end
            S_DIV_M:
            begin
                div_ctl.start      = div_stat.done;
                div_ctl.long_shift = 1'b1;
            end
            default:
            begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    ivwm_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .numer (div_n),
        .denom (div_d),
        .stat  (div_stat),
        .quot  (div_q)
    );

    // Term magnitude is the product scaled down by the fraction, capped at 2^63-1.
    assign t_ovf = |mul_p[PROD_W-1:ACC_W-1+FRACTION_BITS];
    assign t_mag = t_ovf ? {(ACC_W-1){1'b1}} : mul_p[ACC_W-2+FRACTION_BITS:FRACTION_BITS];
    assign t_pos = {1'b0, t_mag};

    // Saturating accumulation: signed weighted sum, unsigned weight total.
    assign ws_sum = {term_reg[ACC_W-1], term_reg} + {ws_reg[ACC_W-1], ws_reg};
    assign ws_ovf = ws_sum[ACC_W] ^ ws_sum[ACC_W-1];
    assign wt_sum = {1'b0, wt_reg} + {1'b0, w_reg};

    // One square-root step: two radicand bits in, one root bit out.
    assign sq_rem_sh = {rem_reg, x_reg[ACC_W-1:ACC_W-2]};
    assign sq_trial  = {1'b0, root_reg, 2'b01};
    assign sq_diff   = sq_rem_sh - sq_trial;
    assign sq_ge     = sq_rem_sh >= sq_trial;

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        neg_next          = neg_reg;
        mag_next          = mag_reg;
        last_next         = last_reg;
        w_next            = w_reg;
        wsat_next         = wsat_reg;
        term_next         = term_reg;
        tsat_next         = tsat_reg;
        ws_next           = ws_reg;
        wt_next           = wt_reg;
        used_next         = used_reg;
        sat_next          = sat_reg;
        mean_stage_next   = mean_stage_reg;
        root_next         = root_reg;
        rem_next          = rem_reg;
        x_next            = x_reg;
        sq_cnt_next       = sq_cnt_reg;
        result_valid_next = result_valid_reg && !result_ready;
        mean_value_next   = mean_value_reg;
        mean_error_next   = mean_error_reg;
        no_samples_next   = no_samples_reg;
        overflowed_next   = overflowed_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next  = sample_value[VALUE_W-1];
                    mag_next  = in_mag;
                    last_next = last_sample;
                    if (use_sample)
                    begin
                        state_next = S_MUL_EE;
                    end
                    else if (last_sample)
                    begin
                        state_next = S_RES;
                    end
                end
            end
            S_MUL_EE:
            begin
                if (mul_done)
                begin
                    state_next = S_DIV_W;
                end
            end
            S_DIV_W:
            begin
                if (div_stat.done)
                begin
                    w_next     = div_q;
                    wsat_next  = div_stat.sat;
                    state_next = S_MUL_VW;
                end
            end
            S_MUL_VW:
            begin
                if (mul_done)
                begin
                    term_next  = neg_reg ? (~t_pos + ACC_W'(1)) : t_pos;
                    tsat_next  = t_ovf;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (ws_ovf)
                begin
                    ws_next = ws_sum[ACC_W] ? SUM_MIN : SUM_MAX;
                end
                else
                begin
                    ws_next = ws_sum[ACC_W-1:0];
                end
                wt_next    = wt_sum[ACC_W] ? {ACC_W{1'b1}} : wt_sum[ACC_W-1:0];
                used_next  = 1'b1;
                sat_next   = sat_reg | wsat_reg | tsat_reg | ws_ovf | wt_sum[ACC_W];
                state_next = last_reg ? S_RES : S_IDLE;
            end
            S_RES:
            begin
                // Empty set and all-zero weights bypass the divisions.
                if (!used_reg)
                begin
                    mean_stage_next = '0;
                    root_next       = '0;
                    state_next      = S_EMIT;
                end
                else if (wt_reg == '0)
                begin
                    mean_stage_next = '0;
                    root_next       = {ROOT_W{1'b1}};
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_DIV_M;
                end
            end
            S_DIV_M:
            begin
                if (div_stat.done)
                begin
                    if (ws_reg[ACC_W-1])
                    begin
                        if (div_q > MEAN_NEG_LIMIT)
                        begin
                            mean_stage_next = MEAN_NEG_LIMIT[VALUE_W-1:0];
                        end
                        else
                        begin
                            mean_stage_next = ~div_q[VALUE_W-1:0] + VALUE_W'(1);
                        end
                    end
                    else
                    begin
                        mean_stage_next = (div_q > MEAN_POS_LIMIT) ?
                                          MEAN_POS_LIMIT[VALUE_W-1:0] : div_q[VALUE_W-1:0];
                    end
                    state_next = S_DIV_E;
                end
            end
            S_DIV_E:
            begin
                if (div_stat.done)
                begin
                    x_next      = div_q;
                    rem_next    = '0;
                    root_next   = '0;
                    sq_cnt_next = SQ_CNT_W'(ROOT_STEPS);
                    state_next  = S_SQRT;
                end
            end
            S_SQRT:
            begin
                x_next      = {x_reg[ACC_W-3:0], 2'b00};
                rem_next    = sq_ge ? sq_diff[REM_W-1:0] : sq_rem_sh[REM_W-1:0];
                root_next   = {root_reg[ROOT_W-2:0], sq_ge};
                sq_cnt_next = sq_cnt_reg - SQ_CNT_W'(1);
                if (sq_cnt_reg == SQ_CNT_W'(1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // Wait for the output register, then hand over and clear the set.
                if (emit_load)
                begin
                    result_valid_next = 1'b1;
                    mean_value_next   = mean_stage_reg;
                    mean_error_next   = root_reg;
                    no_samples_next   = !used_reg;
                    overflowed_next   = sat_reg;
                    ws_next           = '0;
                    wt_next           = '0;
                    used_next         = 1'b0;
                    sat_next          = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ws_reg           <= '0;
            wt_reg           <= '0;
            used_reg         <= 1'b0;
            sat_reg          <= 1'b0;
            sq_cnt_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ws_reg           <= ws_next;
            wt_reg           <= wt_next;
            used_reg         <= used_next;
            sat_reg          <= sat_next;
            sq_cnt_reg       <= sq_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        neg_reg        <= neg_next;
        mag_reg        <= mag_next;
        last_reg       <= last_next;
        w_reg          <= w_next;
        wsat_reg       <= wsat_next;
        term_reg       <= term_next;
        tsat_reg       <= tsat_next;
        mean_stage_reg <= mean_stage_next;
        root_reg       <= root_next;
        rem_reg        <= rem_next;
        x_reg          <= x_next;
        mean_value_reg <= mean_value_next;
        mean_error_reg <= mean_error_next;
        no_samples_reg <= no_samples_next;
        overflowed_reg <= overflowed_next;
    end

    assign result_valid = result_valid_reg;
    assign mean_value   = mean_value_reg;
    assign mean_error   = mean_error_reg;
    assign no_samples   = no_samples_reg;
    assign overflowed   = overflowed_reg;

    // A handed-over result shows on the output and the sequencer is back to idle.
    `IVWM_ASSERT_NEXT(a_emit_visible, clk, rst_n, emit_load,
                      result_valid && (state_reg == S_IDLE))
    // The set is cleared once its result has been handed over.
    `IVWM_ASSERT_NEXT(a_emit_clears, clk, rst_n, emit_load,
                      !used_reg && (wt_reg == '0) && (ws_reg == '0))
    // An empty set reports zero mean and zero error.
    `IVWM_ASSERT_IMPL(a_empty_zero, clk, rst_n, result_valid && no_samples,
                      (mean_value == '0) && (mean_error == '0))
    // The multiplier and the divider never finish in the same cycle.
    `IVWM_ASSERT_IMPL(a_units_apart, clk, rst_n, mul_done, !div_stat.done)

endmodule

// ----- rtl/ivwm_mul.sv -----
// Shift-add multiplier, one bit of operand a per cycle, for the weighted-mean block.
// Depends on ivwm_pkg for the operand widths.
module ivwm_mul
    import ivwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0] op_b,
    output logic               done,
    output logic [PROD_W-1:0]  product
);

    localparam int CNT_W = $clog2(MUL_A_W + 1);

    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [MUL_B_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [MUL_B_W:0]   step_sum;

    // One partial product per cycle: add b into the upper part, then shift right.
    assign step_sum = {1'b0, prod_reg[PROD_W-1:MUL_A_W]}
                    + {1'b0, (prod_reg[0] ? b_reg : {MUL_B_W{1'b0}})};

    always_comb
    begin
        prod_next = prod_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            prod_next = {{MUL_B_W{1'b0}}, op_a};
            b_next    = op_b;
            cnt_next  = CNT_W'(MUL_A_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = {step_sum, prod_reg[MUL_A_W-1:1]};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and product registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        b_reg    <= b_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

// ----- rtl/ivwm_div.sv -----
// Restoring radix-2 divider giving floor(n * 2^s / d), saturated to 64 bits.
// Depends on ivwm_pkg for widths and the command and status types.
module ivwm_div
    import ivwm_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctl_t         ctl,
    input  logic [ACC_W-1:0] numer,
    input  logic [ACC_W-1:0] denom,
    output div_stat_t        stat,
    output logic [ACC_W-1:0] quot
);

    localparam int DVD_W = ACC_W + 3 * FRACTION_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [CNT_W-1:0] LONG_STEPS  = CNT_W'(ACC_W + 3 * FRACTION_BITS);
    localparam logic [CNT_W-1:0] SHORT_STEPS = CNT_W'(ACC_W + FRACTION_BITS);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [ACC_W-1:0] den_reg, den_next;
    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0] q_reg, q_next;
    logic             over_reg, over_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [ACC_W:0]   rem_ext;
    logic [ACC_W:0]   rem_diff;
    logic             q_bit;

    // Bring down the next dividend bit and try one subtraction.
    assign rem_ext  = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff = rem_ext - {1'b0, den_reg};
    assign q_bit    = rem_ext >= {1'b0, den_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        over_next = over_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            // The numerator sits at the top; zeros below supply the 2^s scaling.
            dvd_next  = {numer, {(3 * FRACTION_BITS){1'b0}}};
            den_next  = denom;
            rem_next  = '0;
            q_next    = '0;
            over_next = 1'b0;
            cnt_next  = ctl.long_shift ? LONG_STEPS : SHORT_STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next  = q_bit ? rem_diff[ACC_W-1:0] : rem_ext[ACC_W-1:0];
            over_next = over_reg | q_reg[ACC_W-1];
            q_next    = {q_reg[ACC_W-2:0], q_bit};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        over_reg <= over_next;
    end

    // A quotient that ran past 64 bits reads as all ones.
    assign quot      = over_reg ? {ACC_W{1'b1}} : q_reg;
    assign stat.done = done_reg;
    assign stat.sat  = over_reg;

endmodule

// ----- tb/inverse_variance_weighted_mean_test.sv -----
// Self-checking testbench for the inverse-variance weighted mean block.
// Depends on ivwm_pkg and the inverse_variance_weighted_mean RTL; it predicts
// every result word in a bit-exact scoreboard and compares field by field.
module inverse_variance_weighted_mean_test;
    import ivwm_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int PHASE_WORDS = 475;

    // One expected result word.
    typedef struct {
        logic [VALUE_W-1:0] mean;
        logic [ERROR_W-1:0] err;
        logic               empty;
        logic               ovf;
    } mean_result_t;

    // Running sums of the current sample set and the queue of expected means.
    class mean_scoreboard;
        localparam int FRAC_BITS = ivwm_pkg::FRACTION_BITS_DEF;

        logic signed [63:0] weighted_acc;
        logic [63:0]        weight_acc;
        bit                 samples_used;
        bit                 clipped;
        mean_result_t       pending_means[$];
        int                 mismatches;
        int                 results_seen;
        int                 empty_sets;
        int                 overflow_sets;

        function void clear_set();
            weighted_acc = '0;
            weight_acc   = '0;
            samples_used = 1'b0;
            clipped      = 1'b0;
        endfunction

        // floor(num * 2^sh / den), pinned at all ones when it does not fit 64 bits.
        function logic [63:0] shift_divide(logic [63:0] num, int unsigned sh,
                                           logic [63:0] den, output bit over);
            logic [127:0] wide;
            wide = ({64'd0, num} << sh) / {64'd0, den};
            over = (wide[127:64] != 64'd0);
            return over ? {64{1'b1}} : wide[63:0];
        endfunction

        // Integer square root, one result bit at a time from the top.
        function logic [31:0] int_root(logic [63:0] x);
            logic [31:0] r;
            logic [31:0] cand;
            r = '0;
            for (int b = 31; b >= 0; b--) begin
                cand = r | (32'd1 << b);
                if ({32'd0, cand} * {32'd0, cand} <= x)
                    r = cand;
            end
            return r;
        endfunction

        // Add one used sample: weight 1/e^2 and term v*weight, both saturating.
        function void add_sample(logic [31:0] v, logic [31:0] e);
            logic [63:0]        mag;
            logic [63:0]        w;
            logic [63:0]        t;
            logic [63:0]        e_sq;
            logic [127:0]       prod;
            logic signed [63:0] term;
            logic [64:0]        ssum;
            logic [64:0]        usum;
            bit                 neg;
            bit                 over;
            neg  = v[31];
            mag  = neg ? {32'd0, ~v + 32'd1} : {32'd0, v};
            e_sq = {32'd0, e} * {32'd0, e};
            w    = shift_divide(64'd1, 3 * FRAC_BITS, e_sq, over);
            prod = ({64'd0, mag} * {64'd0, w}) >> FRAC_BITS;
            if (prod > 128'h7FFF_FFFF_FFFF_FFFF) begin
                t    = 64'h7FFF_FFFF_FFFF_FFFF;
                over = 1'b1;
            end
            else
                t = prod[63:0];
            term = neg ? -t : t;

            ssum = {weighted_acc[63], weighted_acc} + {term[63], term};
            if (ssum[64] != ssum[63]) begin
                weighted_acc = ssum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                over         = 1'b1;
            end
            else
                weighted_acc = ssum[63:0];

            usum = {1'b0, weight_acc} + {1'b0, w};
            if (usum[64]) begin
                weight_acc = {64{1'b1}};
                over       = 1'b1;
            end
            else
                weight_acc = usum[63:0];

            samples_used = 1'b1;
            if (over)
                clipped = 1'b1;
        endfunction

        // Form the mean and its error for the finished set, then start a new set.
        function void close_set();
            mean_result_t r;
            logic [63:0]  mag;
            logic [63:0]  q;
            bit           neg;
            bit           ignored;
            r.mean = '0;
            r.err  = '0;
            if (samples_used) begin
                if (weight_acc == 64'd0)
                    r.err = {ERROR_W{1'b1}};
                else begin
                    neg = weighted_acc < 0;
                    mag = neg ? -weighted_acc : weighted_acc;
                    q   = shift_divide(mag, FRAC_BITS, weight_acc, ignored);
                    if (neg) begin
                        if (q > 64'h8000_0000)
                            q = 64'h8000_0000;
                        r.mean = 32'd0 - q[31:0];
                    end
                    else begin
                        if (q > 64'h7FFF_FFFF)
                            q = 64'h7FFF_FFFF;
                        r.mean = q[31:0];
                    end
                    r.err = int_root(shift_divide(64'd1, 3 * FRAC_BITS, weight_acc, ignored));
                end
            end
            r.empty = !samples_used;
            r.ovf   = clipped;
            pending_means.push_back(r);
            clear_set();
        endfunction

        // Called for every accepted sample word.
        function void note_sample(logic [31:0] v, logic [31:0] e, logic nf, logic ex,
                                  logic last);
            if (!nf && !ex && e != 32'd0)
                add_sample(v, e);
            if (last)
                close_set();
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("mismatch on %s: got %h, expected %h", what, got, want);
        endtask

        // Called for every accepted result word.
        task check_result(logic [31:0] mv, logic [31:0] me, logic ns, logic ov);
            mean_result_t want;
            if (pending_means.size() == 0)
                report_mismatch("result word with none expected", mv, 32'd0);
            else begin
                want = pending_means.pop_front();
                results_seen++;
                if (want.empty)
                    empty_sets++;
                if (want.ovf)
                    overflow_sets++;
                if (mv !== want.mean)
                    report_mismatch("mean_value", mv, want.mean);
                if (me !== want.err)
                    report_mismatch("mean_error", me, want.err);
                if (ns !== want.empty)
                    report_mismatch("no_samples", {31'd0, ns}, {31'd0, want.empty});
                if (ov !== want.ovf)
                    report_mismatch("overflowed", {31'd0, ov}, {31'd0, want.ovf});
            end
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      sample_valid;
    logic                      sample_ready;
    logic signed [VALUE_W-1:0] sample_value;
    logic        [ERROR_W-1:0] sample_error;
    logic                      not_finite;
    logic                      excluded;
    logic                      last_sample;
    logic                      result_valid;
    logic                      result_ready;
    logic signed [VALUE_W-1:0] mean_value;
    logic        [ERROR_W-1:0] mean_error;
    logic                      no_samples;
    logic                      overflowed;

    mean_scoreboard sb = new();
    int             sender_idle_pct = 0;
    int             recv_stall_pct = 0;
    logic           output_hold = 1'b0;
    int             words_counted = 0;
    int             cycle_count = 0;

    inverse_variance_weighted_mean #(
        .FRACTION_BITS(FRACTION_BITS_DEF)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_value (sample_value),
        .sample_error (sample_error),
        .not_finite   (not_finite),
        .excluded     (excluded),
        .last_sample  (last_sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .mean_value   (mean_value),
        .mean_error   (mean_error),
        .no_samples   (no_samples),
        .overflowed   (overflowed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** inverse_variance_weighted_mean: FAILED **");
            $finish;
        end
    end

    // Result side: check each accepted word, then choose ready for the next edge.
    initial
    begin
        result_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                sb.check_result(mean_value, mean_error, no_samples, overflowed);
            result_ready <= !output_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one sample word, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_word(input logic [31:0] v, input logic [31:0] e, input logic nf,
                             input logic ex, input logic last);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_value <= v;
        sample_error <= e;
        not_finite   <= nf;
        excluded     <= ex;
        last_sample  <= last;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        sb.note_sample(v, e, nf, ex, last);
        words_counted++;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(3))
            0: return r;
            1: return {{11{r[20]}}, r[20:0]};
            2: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return {{7{r[24]}}, r[24:0]};
        endcase
    endfunction

    function automatic logic [31:0] pick_error();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(1, 32'h0004_0000);
            2: return $urandom_range(1, 255);
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    // One sample set; most sets are short and clean, some are noisy or very long.
    task automatic send_random_set(input int max_len);
        int len;
        int skip_pct;
        logic [31:0] e;
        len      = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, max_len);
        skip_pct = ($urandom_range(9) == 0) ? 50 : 5;
        for (int i = 0; i < len; i++) begin
            e = ($urandom_range(99) < skip_pct) ? 32'd0 : pick_error();
            send_word(pick_value(), e, $urandom_range(99) < skip_pct,
                      $urandom_range(99) < skip_pct, i == len - 1);
        end
    endtask

    // Stimulus.
    initial
    begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        int goal;
        idle_by_phase  = '{0, 62, 0, 8};
        stall_by_phase = '{0, 0, 62, 8};
        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        sample_value   = '0;
        sample_error   = '0;
        not_finite     = 1'b0;
        excluded       = 1'b0;
        last_sample    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sets with nothing used: zero error, excluded, not finite.
        send_word(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
        send_word(32'h0005_0000, 32'h0001_0000, 1'b0, 1'b1, 1'b1);
        send_word(32'h0005_0000, 32'h0001_0000, 1'b1, 1'b0, 1'b1);
        // A plain mixed-sign set.
        send_word(32'h0003_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b0);
        send_word(32'hFFFF_0000, 32'h0002_0000, 1'b0, 1'b0, 1'b1);
        // Most negative value with the smallest error saturates the term.
        send_word(32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0, 1'b1);
        // The weighted sum saturates upward, then downward.
        send_word(32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
        send_word(32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
        send_word(32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 1'b1);
        send_word(32'h8000_0001, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
        send_word(32'h8000_0001, 32'h0000_0001, 1'b0, 1'b0, 1'b1);
        // The largest error truncates the weight to zero, yet the sample counts as used.
        send_word(32'h0007_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_word(32'h0000_0001, 32'h8000_0000, 1'b0, 1'b0, 1'b1);
        // The last sample of a set is skipped but still closes it.
        send_word(32'h0009_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b0);
        send_word(32'h0002_0000, 32'h0003_0000, 1'b0, 1'b0, 1'b0);
        send_word(32'h0000_007B, 32'h0000_0000, 1'b1, 1'b1, 1'b1);
        // Alternating bit patterns.
        send_word(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0);
        send_word(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 1'b0);
        send_word(32'h0000_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b1);

        // Random sets under each idle pattern.
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = idle_by_phase[p];
            recv_stall_pct  = stall_by_phase[p];
            goal            = words_counted + PHASE_WORDS;
            while (words_counted < goal)
                send_random_set(8);
        end

        // Output held off for a long stretch while short sets keep coming.
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        fork
            begin
                output_hold <= 1'b1;
                repeat (3000) @(posedge clk);
                output_hold <= 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++)
                    send_random_set(2);
            end
        join
        sample_valid <= 1'b0;

        // Drain, then allow for a late stray result word.
        while (sb.pending_means.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);

        $display("Sent %0d sample words; checked %0d result words, %0d empty sets,",
                 words_counted, sb.results_seen, sb.empty_sets);
        $display("%0d saturated sets, under four idle patterns and one long output stall.",
                 sb.overflow_sets);
        if (sb.mismatches == 0)
            $display("** inverse_variance_weighted_mean: PASSED **");
        else
            $display("** inverse_variance_weighted_mean: FAILED **");
        $finish;
    end

endmodule
